// ===== hw/rtl/mkw_pkg.sv =====
// shared types, register codes and helpers of the keyword matcher
`default_nettype none

package mkw_pkg;

  localparam int CfgDataW = 64;
  localparam int CfgIdxW  = 3;
  localparam int KwIdxW   = 2;
  localparam int LenNibW  = 4;
  localparam int DelimCntW = 4;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegKwA       = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKwB       = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKwC       = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKwD       = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKwLen     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDelimSet  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDelimCnt  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegCaseSens  = 3'd7;

  localparam logic [7:0] CharLowA   = 8'h61;
  localparam logic [7:0] CharLowZ   = 8'h7a;
  localparam logic [7:0] CaseOffset = 8'h20;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_stream;
  } mkw_req_t;

  typedef struct packed {
    logic [7:0]        byte_out;
    logic              byte_valid;
    logic              match_found;
    logic [KwIdxW-1:0] keyword_index;
    logic              search_failed;
  } mkw_rsp_t;

  // priority chain handed from cell to cell
  typedef struct packed {
    logic              hit;
    logic [KwIdxW-1:0] idx;
  } mkw_chain_t;

  // ascii upper-casing unless exact compare is selected
  function automatic logic [7:0] fold_char(logic [7:0] c, logic exact);
    logic [7:0] r;
    r = c;
    if (!exact && (c >= CharLowA) && (c <= CharLowZ)) begin
      r = c - CaseOffset;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mkw_chan_if.sv =====
// valid/ready channel carrying one request or result payload
`default_nettype none

interface mkw_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mkw_delim.sv =====
// delimiter detector, one compare lane per delimiter slot
`default_nettype none

module mkw_delim #(
  parameter int MAX_DELIMITERS = 8
) (
  input  wire logic [7:0]                    byte_i,
  input  wire logic [MAX_DELIMITERS*8-1:0]   set_i,
  input  wire logic [mkw_pkg::DelimCntW-1:0] count_i,
  output logic                               is_delim_o
);
  import mkw_pkg::*;

  always_comb begin
    is_delim_o = 1'b0;
    for (int j = 0; j < MAX_DELIMITERS; j++) begin
      // slots at or above the count are unused
      if ((count_i > DelimCntW'(j)) && (set_i[8*j +: 8] == byte_i)) begin
        is_delim_o = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mkw_cell.sv =====
// one keyword cell: match position, lock flag and priority chain link
`default_nettype none

module mkw_cell #(
  parameter int MAX_KEYWORD_LEN = 8,
  parameter int KW_IDX          = 0
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           step_i,
  input  wire logic                           clear_i,
  input  wire logic [7:0]                     byte_i,
  input  wire logic                           delim_i,
  input  wire logic                           exact_i,
  input  wire logic [MAX_KEYWORD_LEN*8-1:0]   kw_chars_i,
  input  wire logic [mkw_pkg::LenNibW-1:0]    kw_len_i,
  input  wire mkw_pkg::mkw_chain_t            chain_i,
  output mkw_pkg::mkw_chain_t                 chain_o
);
  import mkw_pkg::*;

  localparam int PosW     = $clog2(MAX_KEYWORD_LEN + 1);
  localparam int CharIdxW = (MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1;

  logic [PosW-1:0] pos_q, pos_d;
  logic            lock_q, lock_d;
  logic [PosW-1:0] len_c;
  logic [PosW-1:0] cmp_pos;
  logic [7:0]      kw_char;
  logic            full;
  logic            char_eq;
  logic            my_hit;

  // oversized length counts as the longest keyword
  assign len_c = (kw_len_i > LenNibW'(MAX_KEYWORD_LEN)) ? PosW'(MAX_KEYWORD_LEN)
                                                       : PosW'(kw_len_i);
  assign full    = (len_c != '0) && (pos_q >= len_c);
  assign my_hit  = full && delim_i;
  assign cmp_pos = full ? '0 : pos_q;
  assign kw_char = kw_chars_i[8*cmp_pos[CharIdxW-1:0] +: 8];
  assign char_eq = (fold_char(kw_char, exact_i) == byte_i);

  always_comb begin
    pos_d  = pos_q;
    lock_d = lock_q;
    if (len_c == '0) begin
      pos_d  = '0;
      lock_d = 1'b0;
    end else if ((pos_q == '0) && delim_i) begin
      lock_d = 1'b0;
    end else if ((pos_q == '0) && lock_q) begin
      lock_d = 1'b1;
    end else begin
      // full word without a delimiter: restart on this byte, locked
      if (full) begin
        lock_d = 1'b1;
      end
      if (char_eq) begin
        pos_d = PosW'(cmp_pos + PosW'(1));
      end else begin
        pos_d  = '0;
        lock_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      lock_q <= 1'b0;
    end else if (clear_i) begin
      pos_q  <= '0;
      lock_q <= 1'b0;
    end else if (step_i) begin
      pos_q  <= pos_d;
      lock_q <= lock_d;
    end
  end

  // lower-numbered cells keep priority
  always_comb begin
    chain_o.hit = chain_i.hit | my_hit;
    if (chain_i.hit) begin
      chain_o.idx = chain_i.idx;
    end else if (my_hit) begin
      chain_o.idx = KwIdxW'(KW_IDX);
    end else begin
      chain_o.idx = '0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/multi_keyword_whole_word_matcher_unit.sv =====
// top level of the multi-keyword whole-word matcher
`default_nettype none

// Scans a byte stream for up to NUM_KEYWORDS keywords that stand as whole
// words and forwards every byte. Each request (one byte, or an end-of-stream
// marker) gives exactly one result in the cycle after it is accepted, held in
// an output register; a new request is taken every cycle, also while a result
// waits, as long as that result is taken in the same cycle. The sustained
// rate is one byte per clock cycle while results are taken. The cycle path runs
// through the delimiter compare, the per-keyword character compare and the
// priority chain through all keyword cells, which decides the reported index
// and the clearing of all cells. A result flags match_found with the lowest
// keyword index on the delimiter that ends a whole word; end of stream gives
// search_failed. Configuration registers reset to their defined values, so
// there is no clearing pass after reset; write them only while idle.
module multi_keyword_whole_word_matcher_unit #(
  parameter int NUM_KEYWORDS    = 4,
  parameter int MAX_KEYWORD_LEN = 8,
  parameter int MAX_DELIMITERS  = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  mkw_chan_if.sink                           req_i,
  mkw_chan_if.source                         rsp_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [mkw_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [mkw_pkg::CfgDataW-1:0]  cfg_data_i
);
  import mkw_pkg::*;

  localparam int KwW    = MAX_KEYWORD_LEN * 8;
  localparam int DelimW = MAX_DELIMITERS * 8;

  // configuration registers
  logic [KwW-1:0]       kw_chars_q [NUM_KEYWORDS];
  logic [LenNibW-1:0]   kw_len_q   [NUM_KEYWORDS];
  logic [DelimW-1:0]    delim_set_q;
  logic [DelimCntW-1:0] delim_cnt_q;
  logic                 exact_q;

  // request side
  mkw_req_t   req;
  logic       req_fire;
  logic       step;
  logic       cell_clear;
  logic [7:0] byte_folded;
  logic       is_delim;
  mkw_chain_t chain [NUM_KEYWORDS+1];

  // result register
  logic     rsp_valid_q;
  mkw_rsp_t rsp_q, rsp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
        kw_chars_q[k] <= '0;
        kw_len_q[k]   <= '0;
      end
      delim_set_q <= '0;
      delim_cnt_q <= '0;
      exact_q     <= 1'b1;
    end else if (cfg_we_i) begin
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
        if (cfg_idx_i == RegKwA + CfgIdxW'(k)) begin
          kw_chars_q[k] <= cfg_data_i[KwW-1:0];
        end
      end
      case (cfg_idx_i)
        RegKwLen: begin
          for (int k = 0; k < NUM_KEYWORDS; k++) begin
            kw_len_q[k] <= cfg_data_i[LenNibW*k +: LenNibW];
          end
        end
        RegDelimSet: begin
          delim_set_q <= cfg_data_i[DelimW-1:0];
        end
        RegDelimCnt: begin
          delim_cnt_q <= cfg_data_i[DelimCntW-1:0];
        end
        RegCaseSens: begin
          exact_q <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign req         = req_i.payload;
  // take a request whenever the result register is free or drains now
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;
  assign step        = req_fire && !req.end_of_stream;
  assign byte_folded = fold_char(req.byte_in, exact_q);

  mkw_delim #(
    .MAX_DELIMITERS (MAX_DELIMITERS)
  ) u_delim (
    .byte_i     (req.byte_in),
    .set_i      (delim_set_q),
    .count_i    (delim_cnt_q),
    .is_delim_o (is_delim)
  );

  // row of keyword cells, priority handed from lowest index upwards
  assign chain[0] = '0;

  for (genvar k = 0; k < NUM_KEYWORDS; k++) begin : g_cell
    mkw_cell #(
      .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN),
      .KW_IDX          (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .step_i     (step),
      .clear_i    (cell_clear),
      .byte_i     (byte_folded),
      .delim_i    (is_delim),
      .exact_i    (exact_q),
      .kw_chars_i (kw_chars_q[k]),
      .kw_len_i   (kw_len_q[k]),
      .chain_i    (chain[k]),
      .chain_o    (chain[k+1])
    );
  end

  // a reported match or the end of stream wipes every cell
  assign cell_clear = req_fire && (req.end_of_stream || chain[NUM_KEYWORDS].hit);

  always_comb begin
    if (req.end_of_stream) begin
      rsp_d.byte_out      = '0;
      rsp_d.byte_valid    = 1'b0;
      rsp_d.match_found   = 1'b0;
      rsp_d.keyword_index = '0;
      rsp_d.search_failed = 1'b1;
    end else begin
      rsp_d.byte_out      = req.byte_in;
      rsp_d.byte_valid    = 1'b1;
      rsp_d.match_found   = chain[NUM_KEYWORDS].hit;
      rsp_d.keyword_index = chain[NUM_KEYWORDS].hit ? chain[NUM_KEYWORDS].idx : '0;
      rsp_d.search_failed = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_fire) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

`ifndef SYNTHESIS
  a_request_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> rsp_valid_q)
    else $error("accepted request left no result");

  a_waiting_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_o.ready) |=> (rsp_valid_q && $stable(rsp_q)))
    else $error("waiting result overwritten or dropped");

  a_match_on_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.match_found) |-> (rsp_q.byte_valid && !rsp_q.search_failed))
    else $error("match reported without a stream byte");

  a_index_only_on_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_q.match_found) |-> (rsp_q.keyword_index == '0))
    else $error("keyword index set without a match");

  a_byte_or_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (rsp_q.byte_valid != rsp_q.search_failed))
    else $error("result neither a byte nor end of stream");
`endif

endmodule

`default_nettype wire

// ===== tb/mkw_match_checker.sv =====
// result predictor and comparator for the keyword matcher, watching channels and register port
module mkw_match_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  input  logic                         req_ready_i,
  input  mkw_pkg::mkw_req_t            req_i,
  input  logic                         rsp_valid_i,
  input  logic                         rsp_ready_i,
  input  mkw_pkg::mkw_rsp_t            rsp_i,
  input  logic                         cfg_we_i,
  input  logic [mkw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mkw_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import mkw_pkg::*;

  localparam logic [7:0] LowerA  = 8'h61;
  localparam logic [7:0] LowerZ  = 8'h7a;
  localparam logic [7:0] CaseBit = 8'h20;

  // shadow copy of the register file
  logic [63:0] kw_chars [4];
  logic [15:0] kw_lens;
  logic [63:0] delim_set;
  logic [3:0]  delim_cnt;
  logic        exact_cmp;

  // per-keyword scan state
  logic [3:0]  kw_pos  [4];
  logic        kw_lock [4];

  mkw_rsp_t    due_results [$];
  mkw_rsp_t    want;
  int          mismatches;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (!exact_cmp && c >= LowerA && c <= LowerZ) begin
      return c & ~CaseBit;
    end
    return c;
  endfunction

  function automatic void clear_cells();
    for (int k = 0; k < 4; k++) begin
      kw_pos[k]  = '0;
      kw_lock[k] = 1'b0;
    end
  endfunction

  // advances the keyword cells by one request and gives the result it must produce
  function automatic mkw_rsp_t next_scan_result(input mkw_req_t r);
    mkw_rsp_t   res;
    logic       delim;
    logic       hit;
    logic [1:0] hit_idx;
    logic [7:0] kc;
    int         n;
    int         len;
    int         pos;
    res     = '0;
    hit     = 1'b0;
    hit_idx = '0;
    delim   = 1'b0;
    if (r.end_of_stream) begin
      clear_cells();
      res.search_failed = 1'b1;
      return res;
    end
    n = (delim_cnt > 8) ? 8 : int'(delim_cnt);
    for (int j = 0; j < n; j++) begin
      if (delim_set[8*j +: 8] == r.byte_in) begin
        delim = 1'b1;
      end
    end
    for (int k = 0; k < 4; k++) begin
      if (!hit) begin
        len = int'(kw_lens[4*k +: 4]);
        if (len > 8) begin
          len = 8;
        end
        pos = int'(kw_pos[k]);
        if (len == 0) begin
          kw_pos[k]  = '0;
          kw_lock[k] = 1'b0;
        end else if (pos == 0 && delim) begin
          kw_lock[k] = 1'b0;
        end else if (!(pos == 0 && kw_lock[k])) begin
          if (pos >= len && delim) begin
            hit     = 1'b1;
            hit_idx = k[1:0];
          end else begin
            // full word not followed by a delimiter: restart on this same byte
            if (pos >= len) begin
              pos        = 0;
              kw_lock[k] = 1'b1;
            end
            kc = kw_chars[k][8*(pos % 8) +: 8];
            if (upcase(kc) == upcase(r.byte_in)) begin
              kw_pos[k] = 4'(pos + 1);
            end else begin
              kw_pos[k]  = '0;
              kw_lock[k] = 1'b1;
            end
          end
        end
      end
    end
    res.byte_out   = r.byte_in;
    res.byte_valid = 1'b1;
    if (hit) begin
      clear_cells();
      res.match_found   = 1'b1;
      res.keyword_index = hit_idx;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        kw_chars[k] = '0;
      end
      kw_lens   = '0;
      delim_set = '0;
      delim_cnt = '0;
      exact_cmp = 1'b1;
      clear_cells();
      due_results.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (due_results.size() == 0) begin
          $error("result with no request outstanding: byte_out %0h", rsp_i.byte_out);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (rsp_i.byte_out !== want.byte_out) begin
            $error("byte_out: expected %0h, got %0h", want.byte_out, rsp_i.byte_out);
            mismatches++;
          end
          if (rsp_i.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, rsp_i.byte_valid);
            mismatches++;
          end
          if (rsp_i.match_found !== want.match_found) begin
            $error("match_found: expected %0b, got %0b", want.match_found, rsp_i.match_found);
            mismatches++;
          end
          if (rsp_i.keyword_index !== want.keyword_index) begin
            $error("keyword_index: expected %0d, got %0d",
                   want.keyword_index, rsp_i.keyword_index);
            mismatches++;
          end
          if (rsp_i.search_failed !== want.search_failed) begin
            $error("search_failed: expected %0b, got %0b",
                   want.search_failed, rsp_i.search_failed);
            mismatches++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        due_results.push_back(next_scan_result(req_i));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegKwA:      kw_chars[0] = cfg_data_i;
          RegKwB:      kw_chars[1] = cfg_data_i;
          RegKwC:      kw_chars[2] = cfg_data_i;
          RegKwD:      kw_chars[3] = cfg_data_i;
          RegKwLen:    kw_lens     = cfg_data_i[15:0];
          RegDelimSet: delim_set   = cfg_data_i;
          RegDelimCnt: delim_cnt   = cfg_data_i[3:0];
          RegCaseSens: exact_cmp   = cfg_data_i[0];
          default: ;
        endcase
      end
      fail_count_o <= mismatches;
      pending_o    <= due_results.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// stimulus and verdict for the multi-keyword whole-word matcher
module testbench;
  import mkw_pkg::*;

  localparam logic [7:0]  LowerA  = 8'h61;
  localparam logic [7:0]  LowerZ  = 8'h7a;
  localparam logic [7:0]  CaseBit = 8'h20;
  // space , . newline nul ; - !
  localparam logic [63:0] PunctPool = 64'h21_2d_3b_00_0a_2e_2c_20;
  localparam int          HalfPhase = 69;

  logic clk_i;
  logic rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  mkw_chan_if #(.payload_t(mkw_req_t)) req_ch ();
  mkw_chan_if #(.payload_t(mkw_rsp_t)) rsp_ch ();

  int fail_count;
  int pending;
  int items_sent;
  int src_gap_pct;
  int snk_stall_pct;

  // register values the stimulus is currently shaped around
  logic [63:0] cfg_kw [4];
  logic [15:0] cfg_lens;
  logic [63:0] cfg_delims;
  logic [3:0]  cfg_dcnt;
  logic        cfg_exact;

  multi_keyword_whole_word_matcher_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_ch.sink),
    .rsp_o      (rsp_ch.source),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  mkw_match_checker u_match_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_ch.valid),
    .req_ready_i  (req_ch.ready),
    .req_i        (req_ch.payload),
    .rsp_valid_i  (rsp_ch.valid),
    .rsp_ready_i  (rsp_ch.ready),
    .rsp_i        (rsp_ch.payload),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  // result side back-pressure, redrawn every cycle
  always @(negedge clk_i) begin
    rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // hard stop in case the block hangs
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // presents one request, with random gaps beforehand, and returns at the accepting edge
  task automatic send_req(input mkw_req_t r);
    while ($urandom_range(99) < src_gap_pct) begin
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    req_ch.valid   <= 1'b1;
    req_ch.payload <= r;
    do @(posedge clk_i); while (!req_ch.ready);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_req(mkw_req_t'{byte_in: b, end_of_stream: 1'b0});
  endtask

  // the byte field carries junk here since the block must ignore it
  task automatic send_eos();
    send_req(mkw_req_t'{byte_in: 8'($urandom_range(255)), end_of_stream: 1'b1});
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  // stop offering requests and wait for every outstanding result
  task automatic wait_results();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
  endtask

  // every register is rewritten each time, the write enable drops only after the last
  task automatic write_config();
    put_reg(RegKwA, cfg_kw[0]);
    put_reg(RegKwB, cfg_kw[1]);
    put_reg(RegKwC, cfg_kw[2]);
    put_reg(RegKwD, cfg_kw[3]);
    put_reg(RegKwLen, 64'(cfg_lens));
    put_reg(RegDelimSet, cfg_delims);
    put_reg(RegDelimCnt, 64'(cfg_dcnt));
    put_reg(RegCaseSens, 64'(cfg_exact));
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = LowerA + 8'($urandom_range(3));
    if ($urandom_range(1) == 0) begin
      c = c & ~CaseBit;
    end
    return c;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c | CaseBit) >= LowerA) && ((c | CaseBit) <= LowerZ);
  endfunction

  // an active delimiter where there is one, else any byte
  function automatic logic [7:0] rand_delim();
    int n;
    n = (cfg_dcnt > 8) ? 8 : int'(cfg_dcnt);
    if (n == 0) begin
      return 8'($urandom_range(255));
    end
    return cfg_delims[8*$urandom_range(n - 1) +: 8];
  endfunction

  // letter keywords in even phases, full-range bytes in odd ones, extremes forced on some
  task automatic randomise_config(input int phase);
    int r;
    for (int k = 0; k < 4; k++) begin
      for (int b = 0; b < 8; b++) begin
        cfg_kw[k][8*b +: 8] = (phase % 2 == 1) ? 8'($urandom_range(255)) : rand_letter();
      end
      r = $urandom_range(11);
      if (r == 0) begin
        cfg_lens[4*k +: 4] = 4'h0;
      end else if (r == 1) begin
        cfg_lens[4*k +: 4] = 4'($urandom_range(15, 9));
      end else begin
        cfg_lens[4*k +: 4] = 4'($urandom_range(8, 1));
      end
    end
    for (int b = 0; b < 8; b++) begin
      cfg_delims[8*b +: 8] = (phase % 2 == 1) ? 8'($urandom_range(255))
                                              : PunctPool[8*$urandom_range(7) +: 8];
    end
    cfg_dcnt  = ($urandom_range(7) == 0) ? 4'($urandom_range(15, 9))
                                         : 4'($urandom_range(8, 1));
    cfg_exact = 1'($urandom_range(1));
    case (phase)
      0: begin
        // first keyword off, oversized length nibble, oversized delimiter count
        cfg_lens[3:0] = 4'h0;
        cfg_lens[7:4] = 4'hf;
        cfg_dcnt      = 4'hf;
        cfg_exact     = 1'b1;
      end
      3: begin
        // no delimiters at all: nothing can ever match
        cfg_lens  = 16'h8888;
        cfg_dcnt  = 4'h0;
        cfg_exact = 1'b0;
      end
      6: begin
        cfg_lens = 16'hffff;
        cfg_dcnt = 4'h8;
      end
      7: begin
        cfg_lens  = 16'h1111;
        cfg_dcnt  = 4'h1;
        cfg_exact = 1'b0;
      end
      default: ;
    endcase
  endtask

  // one of the keywords, sometimes bent, then a delimiter
  task automatic send_keyword_word();
    int         k;
    int         len;
    int         twist;
    logic [7:0] c;
    k     = $urandom_range(3);
    len   = int'(cfg_lens[4*k +: 4]);
    len   = (len > 8) ? 8 : len;
    len   = (len == 0) ? 3 : len;
    twist = $urandom_range(9);
    if (twist == 2) begin
      send_byte(8'($urandom_range(255)));
    end
    for (int i = 0; i < len; i++) begin
      if (!(twist == 0 && i == len - 1)) begin
        c = cfg_kw[k][8*i +: 8];
        if (is_letter(c) && $urandom_range(3) == 0) begin
          c = c ^ CaseBit;
        end
        send_byte(c);
      end
    end
    if (twist == 1) begin
      send_byte(rand_letter());
    end
    send_byte(rand_delim());
  endtask

  // mostly well-formed words with random content, the rest noise and stream ends
  task automatic run_random(input int upto);
    int r;
    int wlen;
    while (items_sent < upto) begin
      r = $urandom_range(99);
      if (r < 55) begin
        send_keyword_word();
      end else if (r < 75) begin
        wlen = $urandom_range(6, 1);
        for (int i = 0; i < wlen; i++) begin
          send_byte(rand_letter());
        end
        send_byte(rand_delim());
      end else if (r < 96) begin
        send_byte(8'($urandom_range(255)));
      end else begin
        send_eos();
      end
    end
  endtask

  initial begin
    int half;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready   = 1'b0;
    items_sent     = 0;
    src_gap_pct    = 0;
    snk_stall_pct  = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: cat / category / a / CAT, case folded, space comma dot and nul as delimiters
    cfg_kw[0]  = 64'h0000_0000_0074_6163;
    cfg_kw[1]  = 64'h7972_6f67_6574_6163;
    cfg_kw[2]  = 64'h0000_0000_0000_0061;
    cfg_kw[3]  = 64'h0000_0000_0054_4143;
    cfg_lens   = 16'h3183;
    cfg_delims = 64'h0000_0000_002e_2c20;
    cfg_dcnt   = 4'h4;
    cfg_exact  = 1'b0;
    write_config();
    send_text("cat ");   // first and fourth keyword tie, lowest index wins
    send_text("Cat.");   // folded compare
    send_text("a,");     // single-character keyword
    send_text("xa ");    // keyword inside a longer word stays locked
    send_byte(8'h00);    // nul listed as a delimiter
    send_eos();
    // length cut below the position reached mid-word counts as a full match
    send_text("categ");
    wait_results();
    cfg_lens = 16'h3133;
    write_config();
    send_text(" ");

    // random phases: none, sender gaps, receiver stalls, both
    for (int phase = 0; phase < 8; phase++) begin
      wait_results();
      randomise_config(phase);
      write_config();
      case (phase % 4)
        0: begin src_gap_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_gap_pct = 79; snk_stall_pct = 0;  end
        2: begin src_gap_pct = 0;  snk_stall_pct = 79; end
        default: begin src_gap_pct = 14; snk_stall_pct = 14; end
      endcase
      half = items_sent + HalfPhase;
      run_random(half);
      // sender holds off mid-phase until every result is back
      wait_results();
      run_random(half + HalfPhase);
    end

    wait_results();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mkw_pkg.sv
hw/rtl/mkw_chan_if.sv
hw/rtl/mkw_delim.sv
hw/rtl/mkw_cell.sv
hw/rtl/multi_keyword_whole_word_matcher_unit.sv
tb/mkw_match_checker.sv
tb/testbench.sv
